// File: hdl/dvm_pkg.sv
// package for the drum voice mixer: widths, opcodes, register indices, constants, command and status structs
// no dependencies
`default_nettype none
package dvm_pkg;
    localparam int VoiceCount  = 8;
    localparam int VoiceW      = $clog2(VoiceCount);
    localparam int SampleWords = 4096;
    localparam int AddrW       = $clog2(SampleWords);
    localparam int PosW        = AddrW + 1;
    localparam int MemAw       = AddrW + 1;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;

    localparam logic [1:0] REG_LEN0  = 2'd0;
    localparam logic [1:0] REG_LEN1  = 2'd1;
    localparam logic [1:0] REG_FLOOR = 2'd2;
    localparam logic [1:0] REG_CEIL  = 2'd3;

    localparam logic [13:0] DacControl = 14'h3000;
    localparam logic [11:0] GainMax    = 12'd4095;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch the item
        logic load;       // write sample word
        logic div_start;  // start gain division
        logic scan_clr;   // clear scan state
        logic scan_step;  // look at voice r_vidx (phase a: issue read)
        logic scan_acc;   // accumulate read result
        logic trig_apply; // apply trigger claim
        logic emit;       // drive result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic scan_last;
    } t_stat;
endpackage
`default_nettype wire

// File: hdl/drum_voice_mixer_unit.sv
// Drum voice mixer: 8-voice drum sample player with voice stealing.
// A tick's length is set by the voice walk and the registered sample memory read;
// a trigger's length is set by the bit-serial gain divider (28 steps) and the voice
// scan; a load writes the sample memory straight from idle.
// A result appears one cycle with o_valid after the tick ends; it cannot be stalled.
// depends on dvm_pkg, dvm_ctrl, dvm_datapath
`default_nettype none
module drum_voice_mixer_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic [1:0]         i_operation,
    input  wire logic [1:0]         i_drum_select,
    input  wire logic [15:0]        i_hit_strength,
    input  wire logic [11:0]        i_load_address,
    input  wire logic signed [15:0] i_load_value,
    output logic                    o_valid,
    output logic [13:0]             o_dac_word,
    output logic signed [11:0]      o_mixed_level
);
    import dvm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dvm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .i_operation, .i_drum_select,
        .i_stat(stat), .busy, .o_cmd(cmd)
    );

    dvm_datapath u_dp (
        .i_clk, .i_rst_n, .cfg_we, .cfg_index, .cfg_data,
        .i_operation, .i_drum_select, .i_hit_strength, .i_load_address,
        .i_load_value, .i_cmd(cmd), .o_stat(stat), .o_strobe(o_valid),
        .o_dac_word, .o_mixed_level
    );

    // checks
    a_dac_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_dac_word[13:12] == 2'b11) else $error("dac control bits");
    a_dac_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_dac_word[10:0] == o_mixed_level[10:0]) else $error("dac mismatch");
    a_valid_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double strobe");
endmodule
`default_nettype wire

// File: hdl/dvm_ctrl.sv
// controller state machine for the drum voice mixer
// depends on dvm_pkg
`default_nettype none
module dvm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    i_operation,
    input  wire logic [1:0]    i_drum_select,
    input  wire dvm_pkg::t_stat i_stat,
    output logic               busy,
    output dvm_pkg::t_cmd      o_cmd
);
    import dvm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_TSCAN = 3'd2,
                           S_TAPP = 3'd3, S_RD = 3'd4, S_ACC = 3'd5, S_EMIT = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture  = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    if (i_operation == OP_TICK) n_state = S_RD;
                    else if (i_drum_select[1]) n_state = S_IDLE;
                    else if (i_operation == OP_TRIGGER) begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_DIV;
                    end else if (i_operation == OP_LOAD) o_cmd.load = 1'b1;
                end
            end
            S_DIV: if (i_stat.div_done) n_state = S_TSCAN;
            S_TSCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_TAPP;
            end
            S_TAPP: begin
                o_cmd.trig_apply = 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                o_cmd.scan_step = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.scan_acc = 1'b1;
                n_state = i_stat.scan_last ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/dvm_datapath.sv
// datapath: config registers, voice table, sample memory, divider, mixer
// depends on dvm_pkg
`default_nettype none
module dvm_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic [1:0]         i_operation,
    input  wire logic [1:0]         i_drum_select,
    input  wire logic [15:0]        i_hit_strength,
    input  wire logic [11:0]        i_load_address,
    input  wire logic signed [15:0] i_load_value,
    input  wire dvm_pkg::t_cmd      i_cmd,
    output dvm_pkg::t_stat          o_stat,
    output logic                    o_strobe,
    output logic [13:0]             o_dac_word,
    output logic signed [11:0]      o_mixed_level
);
    import dvm_pkg::*;

    // config registers
    logic [12:0] r_len0, r_len1;
    logic [15:0] r_floor, r_ceil;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len0 <= '0; r_len1 <= '0; r_floor <= 16'd100; r_ceil <= 16'd1200;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LEN0:  r_len0  <= cfg_data[12:0];
                REG_LEN1:  r_len1  <= cfg_data[12:0];
                REG_FLOOR: r_floor <= cfg_data;
                REG_CEIL:  r_ceil  <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    logic        r_drum;
    logic [15:0] r_hit;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_drum <= i_drum_select[0];
            r_hit  <= i_hit_strength;
        end
    end

    // sample memory
    logic [15:0] mem [2**MemAw];
    logic [15:0] r_rdata;
    logic [MemAw-1:0] rd_addr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) mem[{i_drum_select[0], i_load_address}] <= i_load_value;
        r_rdata <= mem[rd_addr];
    end

    // restoring divider for (hit-floor)*4095/(ceil-floor), one bit per cycle
    logic [27:0] r_num;
    logic [15:0] r_den;
    logic [16:0] r_rem;
    logic [4:0]  r_dcnt;
    logic        r_dact;
    logic [11:0] r_gain;
    logic [16:0] rem_sh, rem_sub;
    logic [15:0] hit_c;
    assign hit_c   = i_hit_strength;
    assign rem_sh  = {r_rem[15:0], r_num[27]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dact <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_num  <= 28'(({12'd0, hit_c - r_floor}) * 28'(GainMax));
            r_den  <= r_ceil - r_floor;
            r_rem  <= '0;
            r_dcnt <= '0;
            r_dact <= 1'b1;
        end else if (r_dact) begin
            if (!rem_sub[16]) begin
                r_rem <= rem_sub;
                r_num <= {r_num[26:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_num <= {r_num[26:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 5'd1;
            if (r_dcnt == 5'd27) r_dact <= 1'b0;
        end
    end
    always_comb begin
        if (r_hit > r_ceil) r_gain = GainMax;
        else if (r_ceil <= r_floor || r_hit < r_floor) r_gain = '0;
        else r_gain = r_num[11:0];
    end
    assign o_stat.div_done = r_dact && (r_dcnt == 5'd27);

    // voice table and scan index
    logic [VoiceCount-1:0] r_busy, r_vdrum;
    logic [PosW-1:0]  r_pos  [VoiceCount];
    logic [11:0]      r_vgain[VoiceCount];
    logic [VoiceW-1:0] r_vidx;
    logic              r_found_idle;
    logic [VoiceW-1:0] r_idle_idx, r_best_idx;
    logic [PosW-1:0]   r_best_pos;
    logic              r_hit_valid; // voice r_vidx played this tick
    logic signed [19:0] r_mix;      // eight full-scale voices need 19 bits
    logic [PosW-1:0]   vlen, len_sel;
    logic [12:0]       len_raw;
    logic              tick_mode;

    assign len_raw = r_vdrum[r_vidx] ? r_len1 : r_len0;
    assign vlen = (len_raw > 13'(SampleWords)) ? PosW'(SampleWords) : PosW'(len_raw);
    assign len_sel = vlen;
    assign rd_addr = {r_vdrum[r_vidx], r_pos[r_vidx][AddrW-1:0]};
    assign o_stat.scan_last = (r_vidx == VoiceW'(VoiceCount - 1));

    // scaled sample: (s*g)>>>12
    logic signed [28:0] prod;
    logic signed [16:0] scaled;
    logic signed [19:0] mix_sum;
    assign prod   = $signed(r_rdata) * $signed({1'b0, r_vgain[r_vidx]});
    assign scaled = prod[28:12];
    assign mix_sum = r_mix + (r_hit_valid ? $signed({{3{scaled[16]}}, scaled}) : 20'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0; r_vdrum <= '0; r_vidx <= '0;
            for (int i = 0; i < VoiceCount; i++) begin
                r_pos[i] <= '0; r_vgain[i] <= '0;
            end
        end else begin
            if (i_cmd.scan_clr) begin
                r_vidx <= '0; r_found_idle <= 1'b0; r_best_pos <= '0;
                r_mix <= '0;
            end
            if (i_cmd.scan_step && !i_cmd.trig_apply && r_dact == 1'b0) begin
                // trigger scan uses only this phase; tick scan reads here
                if (!r_busy[r_vidx] && !r_found_idle) begin
                    r_found_idle <= 1'b1; r_idle_idx <= r_vidx;
                end
                if (r_pos[r_vidx] > r_best_pos) begin
                    r_best_pos <= r_pos[r_vidx]; r_best_idx <= r_vidx;
                end
                r_hit_valid <= r_busy[r_vidx] && (r_pos[r_vidx] < len_sel);
                if (r_busy[r_vidx] && !(r_pos[r_vidx] < len_sel) && !o_stat.div_done
                    && tick_mode)
                    r_busy[r_vidx] <= 1'b0;
                if (!tick_mode) r_vidx <= r_vidx + VoiceW'(1);
            end
            if (i_cmd.scan_acc) begin
                r_mix <= mix_sum;
                if (r_hit_valid) r_pos[r_vidx] <= r_pos[r_vidx] + PosW'(1);
                r_vidx <= r_vidx + VoiceW'(1);
            end
            if (i_cmd.trig_apply && (r_found_idle || r_best_pos != '0)) begin
                r_busy [r_found_idle ? r_idle_idx : r_best_idx] <= 1'b1;
                r_vdrum[r_found_idle ? r_idle_idx : r_best_idx] <= r_drum;
                r_pos  [r_found_idle ? r_idle_idx : r_best_idx] <= '0;
                r_vgain[r_found_idle ? r_idle_idx : r_best_idx] <= r_gain;
            end
        end
    end

    // tick or trigger mode remembered from capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) tick_mode <= (i_operation == OP_TICK);
    end

    // output register with clamp
    logic signed [11:0] clamped;
    always_comb begin
        if (r_mix > 20'sd2047) clamped = 12'sd2047;
        else if (r_mix < -20'sd2048) clamped = -12'sd2048;
        else clamped = r_mix[11:0];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else o_strobe <= i_cmd.emit;
        if (i_cmd.emit) begin
            o_mixed_level <= clamped;
            o_dac_word <= DacControl | {2'b00, clamped[11:0] ^ 12'h800};
        end
    end
endmodule
`default_nettype wire
